### src/efd_pkg.sv
`default_nettype none

package efd_pkg;

  localparam int unsigned MaxPacketDef = 2048;
  localparam int unsigned LenW         = 12;
  localparam int unsigned IdxW         = 11;
  localparam int unsigned CntW         = 32;

  localparam logic [7:0]      FrameReset = 8'h70;
  localparam logic [LenW-1:0] MinReset   = '1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_END     = 2'd2,
    EV_FLUSH   = 2'd3
  } event_kind_t;

  typedef struct packed {
    event_kind_t     kind;
    logic [7:0]      payload_byte;
    logic [IdxW-1:0] byte_index;
    logic [LenW-1:0] packet_length;
    logic [CntW-1:0] packets_seen;
    logic [LenW-1:0] largest_length;
    logic [LenW-1:0] smallest_length;
    logic [CntW-1:0] total_payload;
    logic [CntW-1:0] oversize_bytes;
    logic [CntW-1:0] largest_oversize_run;
    logic [CntW-1:0] flush_count;
  } efd_result_t;

endpackage

`default_nettype wire

### src/efd_core.sv
`default_nettype none

module efd_core #(
  parameter int unsigned MAX_PACKET = efd_pkg::MaxPacketDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                flush,
  input  logic [7:0]          frame_byte,
  output efd_pkg::efd_result_t res
);
  import efd_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PACKET);

  logic            in_escape,       in_escape_next;
  logic [LenW-1:0] cur_length,      cur_length_next;
  logic [CntW-1:0] cur_overrun,     cur_overrun_next;
  logic [CntW-1:0] packet_count,    packet_count_next;
  logic [LenW-1:0] max_length,      max_length_next;
  logic [LenW-1:0] min_length,      min_length_next;
  logic [CntW-1:0] byte_total,      byte_total_next;
  logic [CntW-1:0] discard_count,   discard_count_next;
  logic [CntW-1:0] max_discard_run, max_discard_run_next;
  logic [CntW-1:0] overrun_count,   overrun_count_next;

  logic        take_byte;
  event_kind_t kind;
  logic [7:0]      pbyte;
  logic [IdxW-1:0] pidx;
  logic [LenW-1:0] plen;

  always_comb begin
    in_escape_next       = in_escape;
    cur_length_next      = cur_length;
    cur_overrun_next     = cur_overrun;
    packet_count_next    = packet_count;
    max_length_next      = max_length;
    min_length_next      = min_length;
    byte_total_next      = byte_total;
    discard_count_next   = discard_count;
    max_discard_run_next = max_discard_run;
    overrun_count_next   = overrun_count;
    take_byte = 1'b0;
    kind      = EV_NONE;
    pbyte     = '0;
    pidx      = '0;
    plen      = '0;

    if (flush) begin
      // drop the partial packet, keep the escape flag
      overrun_count_next = overrun_count + 1'b1;
      cur_length_next    = '0;
      cur_overrun_next   = '0;
      kind               = EV_FLUSH;
    end else if (in_escape) begin
      in_escape_next = 1'b0;
      if (rx_byte != frame_byte) begin
        plen              = cur_length;
        packet_count_next = packet_count + 1'b1;
        if (cur_length > max_length) max_length_next = cur_length;
        if (cur_length < min_length) min_length_next = cur_length;
        byte_total_next   = byte_total + CntW'(cur_length);
        cur_length_next   = '0;
        cur_overrun_next  = '0;
        kind              = EV_END;
      end else begin
        take_byte = 1'b1;
      end
    end else if (rx_byte == frame_byte) begin
      in_escape_next = 1'b1;
    end else begin
      take_byte = 1'b1;
    end

    if (take_byte) begin
      if (cur_length >= MaxLen) begin
        cur_overrun_next   = cur_overrun + 1'b1;
        discard_count_next = discard_count + 1'b1;
        if (cur_overrun_next > max_discard_run) max_discard_run_next = cur_overrun_next;
      end else begin
        kind            = EV_PAYLOAD;
        pbyte           = rx_byte;
        pidx            = cur_length[IdxW-1:0];
        cur_length_next = cur_length + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape       <= 1'b0;
      cur_length      <= '0;
      cur_overrun     <= '0;
      packet_count    <= '0;
      max_length      <= '0;
      min_length      <= MinReset;
      byte_total      <= '0;
      discard_count   <= '0;
      max_discard_run <= '0;
      overrun_count   <= '0;
    end else if (step) begin
      in_escape       <= in_escape_next;
      cur_length      <= cur_length_next;
      cur_overrun     <= cur_overrun_next;
      packet_count    <= packet_count_next;
      max_length      <= max_length_next;
      min_length      <= min_length_next;
      byte_total      <= byte_total_next;
      discard_count   <= discard_count_next;
      max_discard_run <= max_discard_run_next;
      overrun_count   <= overrun_count_next;
    end
  end

  always_comb begin
    res.kind                 = kind;
    res.payload_byte         = pbyte;
    res.byte_index           = pidx;
    res.packet_length        = plen;
    res.packets_seen         = packet_count_next;
    res.largest_length       = max_length_next;
    res.smallest_length      = min_length_next;
    res.total_payload        = byte_total_next;
    res.oversize_bytes       = discard_count_next;
    res.largest_oversize_run = max_discard_run_next;
    res.flush_count          = overrun_count_next;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    cur_length <= MaxLen)
    else $error("packet length past maximum");

  a_overrun_at_max: assert property (@(posedge clk) disable iff (rst)
    cur_overrun != '0 |-> cur_length == MaxLen)
    else $error("discard run while packet not full");

  a_run_tracked: assert property (@(posedge clk) disable iff (rst)
    max_discard_run >= cur_overrun)
    else $error("largest discard run below current run");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    max_length <= MaxLen)
    else $error("largest length past maximum");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    step && flush |=> cur_length == '0 && cur_overrun == '0)
    else $error("flush left partial packet state");
`endif

endmodule

`default_nettype wire

### src/escaped_frame_deframer.sv
// Byte-stuffed receive deframer with running statistics.
// Input channel (in_valid/in_ready): one beat carries a received byte or,
// with flush high, a receive-overflow event that drops the partial packet.
// A frame byte followed by a frame byte is one literal payload byte; a frame
// byte followed by anything else ends the packet and eats that byte.
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: the event kind, the payload byte and its index, the
// finished packet length, and the statistics after this beat's update.
// Config channel (cfg_valid/cfg_data): writes the frame byte; always ready,
// write it only while no beats are in flight.
// An accepted beat lands in an input register, is processed by the
// statistics update between the two registers and is captured by the output
// register once that register is free. Throughput is one beat per cycle
// while the receiver keeps out_ready high.
// Reset clears all counters, smallest length to all ones, frame byte to 0x70.
// When the receiver stalls, the result is held and the input register fills;
// in_ready then drops until the output frees up. No beats are lost.
`default_nettype none

module escaped_frame_deframer #(
  parameter int unsigned MAX_PACKET = efd_pkg::MaxPacketDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  input  logic                       flush,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 event_kind,
  output logic [7:0]                 payload_byte,
  output logic [efd_pkg::IdxW-1:0]   byte_index,
  output logic [efd_pkg::LenW-1:0]   packet_length,
  output logic [efd_pkg::CntW-1:0]   packets_seen,
  output logic [efd_pkg::LenW-1:0]   largest_length,
  output logic [efd_pkg::LenW-1:0]   smallest_length,
  output logic [efd_pkg::CntW-1:0]   total_payload,
  output logic [efd_pkg::CntW-1:0]   oversize_bytes,
  output logic [efd_pkg::CntW-1:0]   largest_oversize_run,
  output logic [efd_pkg::CntW-1:0]   flush_count
);
  import efd_pkg::*;

  logic [7:0]  frame_byte;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_flush;

  // result register
  efd_result_t res_next;
  efd_result_t res;

  logic out_free;
  logic advance;

  // advance the held beat whenever the result register is empty or draining
  assign out_free  = !out_valid || out_ready;
  assign advance   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_byte <= FrameReset;
    end else if (cfg_valid) begin
      frame_byte <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= rx_byte;
      s1_flush <= flush;
    end
  end

  efd_core #(
    .MAX_PACKET (MAX_PACKET)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (s1_byte),
    .flush      (s1_flush),
    .frame_byte (frame_byte),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign event_kind           = res.kind;
  assign payload_byte         = res.payload_byte;
  assign byte_index           = res.byte_index;
  assign packet_length        = res.packet_length;
  assign packets_seen         = res.packets_seen;
  assign largest_length       = res.largest_length;
  assign smallest_length      = res.smallest_length;
  assign total_payload        = res.total_payload;
  assign oversize_bytes       = res.oversize_bytes;
  assign largest_oversize_run = res.largest_oversize_run;
  assign flush_count          = res.flush_count;

endmodule

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;
  import efd_pkg::*;

  localparam int unsigned MaxPkt     = MaxPacketDef;
  localparam int unsigned MaxReports = 40;

  // One row of the directed table. Where typed is set, the event fields are
  // taken from the row; otherwise the whole result comes from the predictor.
  typedef struct {
    logic [7:0]      rx;
    logic            fl;
    bit              typed;
    event_kind_t     kind;
    logic [7:0]      pbyte;
    logic [IdxW-1:0] idx;
    logic [LenW-1:0] len;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [7:0]      cfg_data  = 8'h00;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  logic [7:0]      rx_byte   = 8'h00;
  logic            flush     = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      event_kind;
  logic [7:0]      payload_byte;
  logic [IdxW-1:0] byte_index;
  logic [LenW-1:0] packet_length;
  logic [CntW-1:0] packets_seen;
  logic [LenW-1:0] largest_length;
  logic [LenW-1:0] smallest_length;
  logic [CntW-1:0] total_payload;
  logic [CntW-1:0] oversize_bytes;
  logic [CntW-1:0] largest_oversize_run;
  logic [CntW-1:0] flush_count;

  escaped_frame_deframer #(.MAX_PACKET(MaxPkt)) uut (.*);

  always #5 clk = ~clk;

  // Deframer state as the predictor tracks it, plus its copy of the frame byte.
  logic [7:0]      frame_cfg;
  bit              in_esc;
  logic [LenW-1:0] cur_len;
  logic [CntW-1:0] cur_over;
  logic [CntW-1:0] pkt_cnt;
  logic [LenW-1:0] max_len;
  logic [LenW-1:0] min_len;
  logic [CntW-1:0] byte_sum;
  logic [CntW-1:0] drop_cnt;
  logic [CntW-1:0] max_drop_run;
  logic [CntW-1:0] flush_cnt;

  efd_result_t pending_results[$];

  int unsigned beats_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;

  // Directed table, frame byte at its reset value 0x70.
  step_row_t directed_rows [23] = '{
    // flush straight out of reset, byte ignored
    '{8'hFF, 1'b1, 1'b1, EV_FLUSH,   8'h00, 11'd0, 12'd0},
    // payload extremes
    '{8'h00, 1'b0, 1'b1, EV_PAYLOAD, 8'h00, 11'd0, 12'd0},
    '{8'hFF, 1'b0, 1'b1, EV_PAYLOAD, 8'hFF, 11'd1, 12'd0},
    // opening escape, then a stuffed literal frame byte
    '{8'h70, 1'b0, 1'b1, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h70, 1'b0, 1'b1, EV_PAYLOAD, 8'h70, 11'd2, 12'd0},
    // packet end; the terminating byte is eaten
    '{8'h70, 1'b0, 1'b1, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h55, 1'b0, 1'b1, EV_END,     8'h00, 11'd0, 12'd3},
    // empty packet counts too
    '{8'h70, 1'b0, 1'b1, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h01, 1'b0, 1'b1, EV_END,     8'h00, 11'd0, 12'd0},
    // a flush inside an escape keeps the escape open
    '{8'h70, 1'b0, 1'b1, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h70, 1'b1, 1'b1, EV_FLUSH,   8'h00, 11'd0, 12'd0},
    '{8'h33, 1'b0, 1'b1, EV_END,     8'h00, 11'd0, 12'd0},
    // flush drops a partial packet
    '{8'hAA, 1'b0, 1'b1, EV_PAYLOAD, 8'hAA, 11'd0, 12'd0},
    '{8'h55, 1'b0, 1'b1, EV_PAYLOAD, 8'h55, 11'd1, 12'd0},
    '{8'h00, 1'b1, 1'b1, EV_FLUSH,   8'h00, 11'd0, 12'd0},
    // neighbors of the frame byte and a mixed terminator
    '{8'h12, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h70, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'hFF, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h7F, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h71, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h6F, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h70, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0},
    '{8'h00, 1'b0, 1'b0, EV_NONE,    8'h00, 11'd0, 12'd0}
  };

  // Advance the predicted deframer by one beat and return its result.
  function automatic efd_result_t deframe_step(input logic [7:0] b, input logic f);
    efd_result_t r;
    bit          take;
    r      = '0;
    r.kind = EV_NONE;
    take   = 1'b0;
    if (f) begin
      flush_cnt++;
      cur_len  = '0;
      cur_over = '0;
      r.kind   = EV_FLUSH;
    end else if (in_esc) begin
      in_esc = 1'b0;
      if (b != frame_cfg) begin
        r.kind          = EV_END;
        r.packet_length = cur_len;
        pkt_cnt++;
        if (cur_len > max_len) max_len = cur_len;
        if (cur_len < min_len) min_len = cur_len;
        byte_sum += CntW'(cur_len);
        cur_len  = '0;
        cur_over = '0;
      end else begin
        take = 1'b1;
      end
    end else if (b == frame_cfg) begin
      in_esc = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (cur_len >= MaxPkt) begin
        // past the length limit: drop the byte, count the run
        cur_over++;
        drop_cnt++;
        if (cur_over > max_drop_run) max_drop_run = cur_over;
      end else begin
        r.kind         = EV_PAYLOAD;
        r.payload_byte = b;
        r.byte_index   = cur_len[IdxW-1:0];
        cur_len        = cur_len + 1'b1;
      end
    end

    r.packets_seen         = pkt_cnt;
    r.largest_length       = max_len;
    r.smallest_length      = min_len;
    r.total_payload        = byte_sum;
    r.oversize_bytes       = drop_cnt;
    r.largest_oversize_run = max_drop_run;
    r.flush_count          = flush_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxReports) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d, %s: got 0x%0h, want 0x%0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_result(input efd_result_t want);
    check_field("event_kind",           event_kind,           want.kind);
    check_field("payload_byte",         payload_byte,         want.payload_byte);
    check_field("byte_index",           byte_index,           want.byte_index);
    check_field("packet_length",        packet_length,        want.packet_length);
    check_field("packets_seen",         packets_seen,         want.packets_seen);
    check_field("largest_length",       largest_length,       want.largest_length);
    check_field("smallest_length",      smallest_length,      want.smallest_length);
    check_field("total_payload",        total_payload,        want.total_payload);
    check_field("oversize_bytes",       oversize_bytes,       want.oversize_bytes);
    check_field("largest_oversize_run", largest_oversize_run, want.largest_oversize_run);
    check_field("flush_count",          flush_count,          want.flush_count);
    results_checked++;
  endtask

  // Sample the result channel at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) report_mismatch("result beat with nothing expected");
      else check_result(pending_results.pop_front());
    end
  end

  // Receiver: stall at random, at the rate the current phase asks.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one beat. Valid may stay high from the previous beat; drop it only
  // for a sender gap. Queue the expectation before the beat can be taken.
  task automatic send_beat(input logic [7:0] b, input logic f, input efd_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    pending_results.push_back(want);
    in_valid = 1'b1;
    rx_byte  = b;
    flush    = f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] b, input logic f);
    send_beat(b, f, deframe_step(b, f));
  endtask

  // Release the input and hold until every queued result has come back.
  task automatic settle_outputs();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_frame(input logic [7:0] v);
    settle_outputs();
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    frame_cfg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Payload byte biased toward the frame byte (forces stuffing) and extremes.
  function automatic logic [7:0] pick_payload();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return frame_cfg;
    if (roll < 25) return 8'h00;
    if (roll < 30) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Send one well-formed stuffed packet, closed by a terminator or a flush.
  task automatic send_packet(input int unsigned len, input bit end_flush);
    logic [7:0] b;
    logic [7:0] term;
    for (int unsigned i = 0; i < len; i++) begin
      b = pick_payload();
      if (b == frame_cfg) feed(b, 1'b0);
      feed(b, 1'b0);
    end
    if (end_flush) begin
      feed(8'($urandom_range(255)), 1'b1);
    end else begin
      do term = 8'($urandom_range(255)); while (term == frame_cfg);
      feed(frame_cfg, 1'b0);
      feed(term, 1'b0);
    end
  endtask

  // Mostly short packets with random content, some noise and broken escapes,
  // then one packet that reaches the length limit and may run past it.
  task automatic run_traffic(input int unsigned budget, input bit long_end_flush);
    int unsigned start_count;
    int unsigned roll;
    start_count = beats_sent;
    while (beats_sent - start_count < budget) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        send_packet(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8),
                    $urandom_range(19) == 0);
      end else if (roll < 88) begin
        feed(8'($urandom_range(255)), 1'b1);
      end else if (roll < 95) begin
        feed(8'($urandom_range(255)), 1'b0);
      end else begin
        // escape left open across a flush
        feed(frame_cfg, 1'b0);
        feed(8'($urandom_range(255)), 1'b1);
      end
    end
    send_packet(MaxPkt + $urandom_range(40), long_end_flush);
  endtask

  initial begin
    efd_result_t want;

    frame_cfg    = FrameReset;
    in_esc       = 1'b0;
    cur_len      = '0;
    cur_over     = '0;
    pkt_cnt      = '0;
    max_len      = '0;
    min_len      = MinReset;
    byte_sum     = '0;
    drop_cnt     = '0;
    max_drop_run = '0;
    flush_cnt    = '0;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed table at the reset frame byte, light sender and heavy receiver idling.
    send_idle_pct = 18;
    recv_idle_pct = 58;
    for (int i = 0; i < $size(directed_rows); i++) begin
      want = deframe_step(directed_rows[i].rx, directed_rows[i].fl);
      if (directed_rows[i].typed) begin
        want.kind          = directed_rows[i].kind;
        want.payload_byte  = directed_rows[i].pbyte;
        want.byte_index    = directed_rows[i].idx;
        want.packet_length = directed_rows[i].len;
      end
      send_beat(directed_rows[i].rx, directed_rows[i].fl, want);
    end

    // Frame byte at its top extreme; the long packet is dropped by a flush.
    write_frame(8'hFF);
    run_traffic(300, 1'b1);

    // Frame byte at zero, sender now the one that idles more.
    write_frame(8'h00);
    send_idle_pct = 58;
    recv_idle_pct = 18;
    run_traffic(300, 1'b0);

    // Random frame byte at full rate.
    write_frame(8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(250, 1'b0);

    // Drain, then give the two-stage pipeline room to show any stray beat.
    settle_outputs();
    repeat (8) @(negedge clk);

    $display("Ran %0d beats over four frame byte settings, %0d results compared.",
             beats_sent, results_checked);
    $display("Covered %0d packets, %0d flushes, %0d oversize bytes dropped; %0d mismatches.",
             pkt_cnt, flush_cnt, drop_cnt, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/efd_pkg.sv
src/efd_core.sv
src/escaped_frame_deframer.sv
verif/testbench.sv
